[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; both macros expect clk in scope, PNGU_ASSERT also rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, muted while reset is asserted
`define PNGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that is also checked during reset
`define PNGU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pngu_pkg.sv]
`timescale 1ns / 1ps
// package for the png scanline unfilter: sizes, filter codes, neighbor struct
// no dependencies
package pngu_pkg;

  localparam int MAX_ROW_BYTES = 16384;
  localparam int MAX_BPP       = 8;
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);
  localparam int SLOT_W        = $clog2(MAX_BPP);
  localparam int BPP_W         = 4;

  localparam logic [BPP_W-1:0] BPP_MIN   = BPP_W'(1);
  localparam logic [BPP_W-1:0] BPP_MAX   = BPP_W'(MAX_BPP);
  localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(1);

  // row filter codes
  localparam logic [7:0] FLT_NONE  = 8'd0;
  localparam logic [7:0] FLT_SUB   = 8'd1;
  localparam logic [7:0] FLT_UP    = 8'd2;
  localparam logic [7:0] FLT_AVG   = 8'd3;
  localparam logic [7:0] FLT_PAETH = 8'd4;

  // left, upper and upper-left neighbors of the current byte
  typedef struct packed {
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] up_left;
  } pngu_nbr_t;

endpackage

[rtl/pngu_predict.sv]
`timescale 1ns / 1ps
// filter predictor: none, sub, up, average and paeth, result modulo 256
// depends on pngu_pkg
module pngu_predict (
  input  pngu_pkg::pngu_nbr_t nbr,
  input  logic [7:0]          filter_type,
  input  logic [7:0]          raw_byte,
  output logic [7:0]          pixel_byte,
  output logic                bad_filter
);

  logic signed [9:0] p;
  logic signed [9:0] da;
  logic signed [9:0] db;
  logic signed [9:0] dc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;

  // paeth distances in 10-bit signed arithmetic
  always_comb begin
    p  = $signed({2'b00, nbr.left}) + $signed({2'b00, nbr.up})
         - $signed({2'b00, nbr.up_left});
    da = p - $signed({2'b00, nbr.left});
    db = p - $signed({2'b00, nbr.up});
    dc = p - $signed({2'b00, nbr.up_left});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = nbr.left;
    end else if (pb <= pc) begin
      paeth = nbr.up;
    end else begin
      paeth = nbr.up_left;
    end
  end

  assign avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};

  always_comb begin
    bad_filter = 1'b0;
    unique case (filter_type)
      pngu_pkg::FLT_NONE:  pred = 8'd0;
      pngu_pkg::FLT_SUB:   pred = nbr.left;
      pngu_pkg::FLT_UP:    pred = nbr.up;
      pngu_pkg::FLT_AVG:   pred = avg_sum[8:1];
      pngu_pkg::FLT_PAETH: pred = paeth;
      default: begin
        pred       = 8'd0;
        bad_filter = 1'b1;
      end
    endcase
  end

  assign pixel_byte = raw_byte + pred;

endmodule

[rtl/png_scanline_unfilter.sv]
`timescale 1ns / 1ps
// png scanline unfilter top level: line store, byte history, output register
// depends on pngu_pkg and pngu_predict
//
//  channel  dir  tdata            tuser                          tlast
//  in_      in   raw_byte [7:0]   filter_type [7:0], first_row   row_end
//  out_     out  pixel_byte [7:0] bad_filter                     row_done
//  cfg_     in   bytes_per_pixel on cfg_wdata, written when cfg_wen is high
//
// one item per cycle while out_tready stays high; items pass stage 1, then the
// output register behind out_tvalid; the line store read is issued at accept
// rst_n (synchronous) clears column, history, bytes per pixel (to 1) and valids
// the line store is not cleared: a row must be seen before it serves as upper row
// a stalled output holds stage 1, which drops in_tready; no item is lost
module png_scanline_unfilter (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] raw_byte
  input  logic [8:0] in_tuser,   // [7:0] filter_type, [8] first_row
  input  logic       in_tlast,   // row_end
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] pixel_byte
  output logic [0:0] out_tuser,  // [0] bad_filter
  output logic       out_tlast,  // row_done
  // configuration
  input  logic       cfg_wen,
  input  logic [3:0] cfg_wdata   // bytes_per_pixel
);

  localparam int COL_W  = pngu_pkg::COL_W;
  localparam int SLOT_W = pngu_pkg::SLOT_W;
  localparam int BPP_W  = pngu_pkg::BPP_W;

  // line store: previous reconstructed row, read at accept, written from stage 1
  logic [7:0] line_mem [pngu_pkg::MAX_ROW_BYTES];
  logic [7:0] line_q_r;

  // last bytes of the current row, one slot per byte lane
  logic [7:0] left_hist_r [pngu_pkg::MAX_BPP];
  logic [7:0] ul_hist_r   [pngu_pkg::MAX_BPP];

  logic [BPP_W-1:0] bpp_r;
  logic [BPP_W-1:0] bpp_nxt;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;

  // stage 1 holds the item whose upper byte is coming out of the line store
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [7:0]       s1_raw_r;
  logic [7:0]       s1_ftype_r;
  logic             s1_first_r;
  logic             s1_last_r;
  logic             s1_fwd_r;     // line store read raced a write to the same column
  logic [7:0]       s1_fwd_data_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             out_bad_r;

  logic             in_acc;
  logic             out_free;
  logic             s1_adv;
  logic             has_left;
  logic [SLOT_W-1:0] left_slot;
  logic [SLOT_W-1:0] cur_slot;
  logic [7:0]       up_byte;
  pngu_pkg::pngu_nbr_t nbr;
  logic [7:0]       result;
  logic             bad;

  // handshake: stage 1 moves on when the output register is empty or drained
  assign out_free = !out_valid_r || out_tready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_tready);

  // bytes per pixel, out-of-range values clamped at write
  always_comb begin
    bpp_nxt = bpp_r;
    if (cfg_wen) begin
      if (cfg_wdata < pngu_pkg::BPP_MIN) begin
        bpp_nxt = pngu_pkg::BPP_MIN;
      end else if (cfg_wdata > pngu_pkg::BPP_MAX) begin
        bpp_nxt = pngu_pkg::BPP_MAX;
      end else begin
        bpp_nxt = cfg_wdata;
      end
    end
  end

  // column counter: back to zero after row end, wraps at the store depth
  always_comb begin
    col_nxt = col_r;
    if (in_acc) begin
      col_nxt = in_tlast ? '0 : col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= pngu_pkg::BPP_RESET;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bpp_r       <= bpp_nxt;
      col_r       <= col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1 payload, loaded at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r      <= col_r;
      s1_raw_r      <= in_tdata;
      s1_ftype_r    <= in_tuser[7:0];
      s1_first_r    <= in_tuser[8];
      s1_last_r     <= in_tlast;
      s1_fwd_r      <= s1_adv && (s1_col_r == col_r);
      s1_fwd_data_r <= result;
    end
  end

  // line store port: read at accept, write back the reconstructed byte
  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_q_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= result;
    end
  end

  // neighbor selection
  assign has_left  = s1_col_r >= COL_W'(bpp_r);
  assign left_slot = s1_col_r[SLOT_W-1:0] - bpp_r[SLOT_W-1:0];
  assign cur_slot  = s1_col_r[SLOT_W-1:0];

  always_comb begin
    up_byte = s1_fwd_r ? s1_fwd_data_r : line_q_r;
    nbr.up      = s1_first_r ? 8'd0 : up_byte;
    nbr.left    = has_left ? left_hist_r[left_slot] : 8'd0;
    nbr.up_left = (has_left && !s1_first_r) ? ul_hist_r[left_slot] : 8'd0;
  end

  pngu_predict u_predict (
    .nbr         (nbr),
    .filter_type (s1_ftype_r),
    .raw_byte    (s1_raw_r),
    .pixel_byte  (result),
    .bad_filter  (bad)
  );

  // byte history of the current row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pngu_pkg::MAX_BPP; i++) begin
        left_hist_r[i] <= 8'd0;
        ul_hist_r[i]   <= 8'd0;
      end
    end else if (s1_adv) begin
      left_hist_r[cur_slot] <= result;
      ul_hist_r[cur_slot]   <= nbr.up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
      out_last_r <= s1_last_r;
      out_bad_r  <= bad;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_bad_r;

endmodule

[rtl/pngu_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the png scanline unfilter, bound to the top level
// depends on assert_macros.svh
module pngu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

`include "assert_macros.svh"

  // nothing comes out right after reset
  `PNGU_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_tvalid, "output valid after reset")

  // an empty output register never blocks the input
  `PNGU_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with output empty")

  // a stalled result stays offered
  `PNGU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output valid dropped")

  // a stalled result keeps its value
  `PNGU_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata),
    "output data changed while stalled")

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for png_scanline_unfilter: directed rows, register sweep,
// random rows with stalls on both sides and a closing stretch without idling
// depends on pngu_pkg and the png_scanline_unfilter rtl
module tb;

  // filter codes past paeth, both must raise the error flag
  localparam logic [7:0] FLT_BAD_LOW  = 8'd5;
  localparam logic [7:0] FLT_BAD_HIGH = 8'hFF;
  // cycles without any accepted item before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // cycles to let the pipe settle once nothing is pending
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [7:0] pixel;
    logic       done;
    logic       bad;
  } pixel_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] raw_byte
  logic [8:0] in_tuser = '0;   // [7:0] filter_type, [8] first_row
  logic       in_tlast = 1'b0; // row_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [7:0] pixel_byte
  logic [0:0] out_tuser;       // [0] bad_filter
  logic       out_tlast;       // row_done
  logic       cfg_wen = 1'b0;
  logic [3:0] cfg_wdata = '0;  // bytes_per_pixel

  png_scanline_unfilter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mirror of the line store, byte history and row position
  // ---------------------------------------------------------------------------
  logic [7:0] line_store [pngu_pkg::MAX_ROW_BYTES];
  logic [7:0] left_hist [pngu_pkg::MAX_BPP] = '{default: '0};
  logic [7:0] up_left_hist [pngu_pkg::MAX_BPP] = '{default: '0};
  int         row_col = 0;
  logic [3:0] bpp_reg = pngu_pkg::BPP_RESET;
  // columns below this one have been written at least once
  int         store_fill = 0;

  pixel_result_t pixel_q [$];   // reconstructed bytes still to come out
  int  fail_count = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;             // no idling on either side while set
  int  ready_hold = 0;
  int  hang_count = 0;

  function automatic int paeth_choice(int a, int b, int c);
    int p, da, db, dc;
    p  = a + b - c;
    da = (p > a) ? p - a : a - p;
    db = (p > b) ? p - b : b - p;
    dc = (p > c) ? p - c : c - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // reconstruct one byte and advance the row state
  function automatic pixel_result_t unfilter_byte(logic [7:0] raw, logic [7:0] ftype,
                                                  logic first, logic last);
    int eff_bpp, col, slot, a, b, c, pred;
    pixel_result_t r;
    // out of range register values clamp to 1..MAX_BPP
    eff_bpp = (bpp_reg == 0) ? 1 :
              (bpp_reg > pngu_pkg::MAX_BPP) ? pngu_pkg::MAX_BPP : int'(bpp_reg);
    col = row_col;
    a = 0;
    b = 0;
    c = 0;
    if (!first) b = line_store[col];
    // left edge: no left or upper-left neighbor yet
    if (col >= eff_bpp) begin
      slot = (col - eff_bpp) % pngu_pkg::MAX_BPP;
      a = left_hist[slot];
      if (!first) c = up_left_hist[slot];
    end
    r.bad = 1'b0;
    case (ftype)
      pngu_pkg::FLT_NONE:  pred = 0;
      pngu_pkg::FLT_SUB:   pred = a;
      pngu_pkg::FLT_UP:    pred = b;
      pngu_pkg::FLT_AVG:   pred = (a + b) / 2;
      pngu_pkg::FLT_PAETH: pred = paeth_choice(a, b, c);
      default: begin
        pred = 0;
        r.bad = 1'b1;
      end
    endcase
    r.pixel = 8'(int'(raw) + pred);
    r.done  = last;
    left_hist[col % pngu_pkg::MAX_BPP]    = r.pixel;
    up_left_hist[col % pngu_pkg::MAX_BPP] = 8'(b);
    line_store[col] = r.pixel;
    if (col + 1 > store_fill) store_fill = col + 1;
    // the column wraps past the end of the line store
    row_col = last ? 0 : (col + 1) % pngu_pkg::MAX_ROW_BYTES;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: out_tready dropped in random bursts of stall cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expected byte
  always @(posedge clk) begin : check_out
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        note_failure($sformatf("unexpected item pixel %02h done %0b bad %0b",
                               out_tdata, out_tlast, out_tuser[0]));
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata !== want.pixel || out_tlast !== want.done || out_tuser[0] !== want.bad)
          note_failure($sformatf("pixel %02h/%02h done %0b/%0b bad %0b/%0b (exp/got)",
                                 want.pixel, out_tdata, want.done, out_tlast,
                                 want.bad, out_tuser[0]));
      end
    end
  end

  // hang detection: any accepted item on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("[png_scanline_unfilter] ERROR");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // present one byte, wait for the accept edge, then maybe idle for a burst
  task automatic send_byte(logic [7:0] raw, logic [7:0] ftype, logic first, logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tuser  <= {first, ftype};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pixel_q.insert(pixel_q.size(), unfilter_byte(raw, ftype, first, last));
    items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold the input until every expected byte is out and the pipe is empty
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bpp(logic [3:0] value);
    drain_pipe();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    bpp_reg = value;
  endtask

  // one scanline; the upper row is used only where the line store was written
  task automatic send_row(int len, bit want_upper, bit noisy);
    logic [7:0] row_ft, ftype;
    logic       first;
    row_ft = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 4));
    for (int i = 0; i < len; i++) begin
      ftype = row_ft;
      first = !(want_upper && row_col < store_fill);
      // broken rows: filter changes mid-row and stray first-row flags
      if (noisy && $urandom_range(0, 7) == 0) ftype = 8'($urandom_range(0, 255));
      if (noisy && $urandom_range(0, 9) == 0) first = 1'b1;
      send_byte(8'($urandom_range(0, 255)), ftype, first, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every filter, bad codes, byte extremes, left edge and first row at reset bpp
  task automatic test_directed();
    logic [7:0] top_ft [8] = '{pngu_pkg::FLT_NONE, pngu_pkg::FLT_SUB, pngu_pkg::FLT_UP,
                               pngu_pkg::FLT_AVG, pngu_pkg::FLT_PAETH, FLT_BAD_LOW,
                               FLT_BAD_HIGH, pngu_pkg::FLT_PAETH};
    logic [7:0] top_raw [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h33, 8'hC4, 8'hFF};
    logic [7:0] low_ft [8] = '{pngu_pkg::FLT_NONE, pngu_pkg::FLT_SUB, pngu_pkg::FLT_UP,
                               pngu_pkg::FLT_AVG, pngu_pkg::FLT_PAETH, FLT_BAD_LOW,
                               pngu_pkg::FLT_PAETH, pngu_pkg::FLT_SUB};
    logic [7:0] low_raw [8] = '{8'hFF, 8'h01, 8'hFF, 8'h80, 8'h00, 8'h10, 8'hFE, 8'h55};
    // first row of an image: no upper neighbor
    for (int i = 0; i < 8; i++) send_byte(top_raw[i], top_ft[i], 1'b1, i == 7);
    // second row uses the one above
    for (int i = 0; i < 8; i++) send_byte(low_raw[i], low_ft[i], 1'b0, i == 7);
    // widest pixel: the whole row sits on the left edge
    write_bpp(pngu_pkg::BPP_MAX);
    for (int i = 0; i < 8; i++) send_byte(8'(8'hF0 + i), pngu_pkg::FLT_PAETH, 1'b0, i == 7);
  endtask

  // every register value, out of range ones included
  task automatic test_bpp_sweep();
    for (int v = 15; v >= 0; v--) begin
      write_bpp(4'(v));
      send_row($urandom_range(3, 20), 1'b1, 1'b0);
      send_row($urandom_range(3, 20), 1'b1, 1'b0);
    end
  endtask

  // mostly well-formed rows of random content, some broken, bpp changes now and then
  task automatic test_random_rows(int target);
    int goal, len;
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(0, 11) == 0) write_bpp(4'($urandom_range(0, 15)));
      else if ($urandom_range(0, 19) == 0) drain_pipe();
      calm = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
      send_row(len, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
    end
    calm = 1'b0;
  endtask

  // closing stretch without idling on either side
  task automatic test_steady(int target);
    int goal;
    calm = 1'b1;
    goal = items_sent + target;
    while (items_sent < goal) send_row($urandom_range(1, 40), 1'b1, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_bpp_sweep();
    test_random_rows(1100);
    test_steady(200);
    drain_pipe();
    if (pixel_q.size() != 0) note_failure($sformatf("%0d results never came", pixel_q.size()));
    if (fail_count == 0) begin
      $display("[png_scanline_unfilter] OK");
    end else begin
      $display("[png_scanline_unfilter] ERROR");
    end
    $finish;
  end

endmodule

[png_scanline_unfilter.f]
+incdir+rtl
rtl/pngu_pkg.sv
rtl/pngu_predict.sv
rtl/png_scanline_unfilter.sv
rtl/pngu_checker.sv
test/tb.sv
